// File: rtl/core/text_terminal_char_writer_unit_assert.svh
// Assertion macros used by the checker of the character writer.
`ifndef TEXT_TERMINAL_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTCW_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("ttcw: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTCW_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("ttcw: next-cycle check failed");

`endif

// File: rtl/core/ttcw_pkg.sv
// Package: types, byte codes and field widths of the character writer.
`default_nettype none
package ttcw_pkg;

    localparam int CHAR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int CROW_W   = 5;
    localparam int CCOL_W   = 7;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [BYTE_W-1:0] BYTE_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_ESC = 8'h1B;

    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_END_LO = 8'h40;
    localparam logic [BYTE_W-1:0] ESC_END_HI = 8'h7E;

    localparam logic [CHAR_W-1:0] CHAR_BLANK = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    localparam int TAB_STEP = 8;

    // Memory request control travelling from the address unit to the store.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_PUT    = 7'b0010000,
        ST_RDA    = 7'b0100000,
        ST_RDB    = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/text_terminal_char_writer_unit.sv
// Top level: sequencer, cursor and escape state of the text terminal character writer.
`default_nettype none
// Text terminal character writer. Items are accepted on a rising edge with start
// high and busy low; each item gives exactly one result, shown for a single cycle
// with done high, and the receiver cannot hold it off, so capture it on that edge.
// Steps per item, all set by the one shared address unit and the single-port
// screen memory behind it: a feed byte is accepted, then decoded with its memory
// write request; a cell read goes through address, memory read and registered
// data, with no memory read when the cell lies off the screen. A feed that moves
// below the bottom row scrolls: the scroll is a change of the row offset plus one
// blanking write per column, and a wrapped printable byte that scrolls is written
// after the blanking. After reset the block sweeps all ROWS*COLUMNS cells (3200 at
// the default size) to spaces, one cell a cycle, and holds busy high meanwhile.
// Result fields: cell_char is the read character (0 for a feed), cursor_row and
// cursor_col give the cursor after the item (cursor_col equal to COLUMNS means
// a wrap is pending) and in_escape is high while an escape sequence is being
// swallowed. Cursor fields are masked to their port widths.
module text_terminal_char_writer_unit
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = 100,
    parameter int ROWS    = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  wire logic              operation,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic [RROW_W-1:0] read_row,
    input  wire logic [RCOL_W-1:0] read_col,
    output logic [CHAR_W-1:0]      cell_char,
    output logic [CROW_W-1:0]      cursor_row,
    output logic [CCOL_W-1:0]      cursor_col,
    output logic                   in_escape
);

    localparam int RW    = $clog2(ROWS);
    localparam int CXW   = $clog2(COLUMNS);
    localparam int CCW   = $clog2(COLUMNS + 1);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    // Sequencer and item registers.
    state_t              state_reg,     state_next;
    logic                op_reg,        op_next;
    logic [BYTE_W-1:0]   byte_reg,      byte_next;
    logic [RROW_W-1:0]   rrow_reg,      rrow_next;
    logic [RCOL_W-1:0]   rcol_reg,      rcol_next;

    // Cursor, escape and scroll offset.
    logic [RW-1:0]       cur_row_reg,   cur_row_next;
    logic [CCW-1:0]      cur_col_reg,   cur_col_next;
    logic                esc_reg,       esc_next;
    logic [RW-1:0]       top_reg,       top_next;

    // Sweep counters: the column counter is shared by the reset clear and the scroll blanking.
    logic [RW-1:0]       sweep_row_reg, sweep_row_next;
    logic [CXW-1:0]      sweep_col_reg, sweep_col_next;
    logic                put_reg,       put_next;

    // Result registers.
    logic                done_reg,      done_next;
    logic [CHAR_W-1:0]   cell_char_reg, cell_char_next;

    // Request to the shared address unit.
    mem_ctl_t            req_ctl;
    logic [RW-1:0]       req_row;
    logic [CXW-1:0]      req_col;
    logic [CHAR_W-1:0]   req_data;

    mem_ctl_t            mem_ctl;
    logic [AW-1:0]       mem_addr;
    logic [CHAR_W-1:0]   mem_data;
    logic [CHAR_W-1:0]   mem_rdata;

    logic [CCW:0]        tab_sum;
    logic [CCW:0]        tab_stop;
    logic [RW-1:0]       top_adv;
    logic                last_row;
    logic                col_at_end;
    logic                read_in_range;

    always_comb
    begin
        tab_sum       = {1'b0, cur_col_reg} + (CCW+1)'(TAB_STEP);
        tab_stop      = tab_sum & ~(CCW+1)'(TAB_STEP - 1);
        top_adv       = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
        last_row      = (cur_row_reg == RW'(ROWS - 1));
        col_at_end    = (cur_col_reg >= CCW'(COLUMNS));
        read_in_range = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        rrow_next      = rrow_reg;
        rcol_next      = rcol_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        esc_next       = esc_reg;
        top_next       = top_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        put_next       = put_reg;
        done_next      = 1'b0;
        cell_char_next = cell_char_reg;
        req_ctl        = '0;
        req_row        = cur_row_reg;
        req_col        = CXW'(cur_col_reg);
        req_data       = CHAR_BLANK;

        case (state_reg)
            ST_CLEAR:
            begin
                // Blank every cell; the row offset is still zero here.
                req_ctl.we = 1'b1;
                req_row    = sweep_row_reg;
                req_col    = sweep_col_reg;
                if (sweep_col_reg == CXW'(COLUMNS - 1))
                begin
                    sweep_col_next = '0;
                    if (sweep_row_reg == RW'(ROWS - 1))
                    begin
                        sweep_row_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        sweep_row_next = sweep_row_reg + RW'(1);
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + CXW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    byte_next  = data_byte;
                    rrow_next  = read_row;
                    rcol_next  = read_col;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (op_reg == OP_READ)
                begin
                    if (read_in_range)
                    begin
                        req_ctl.re = 1'b1;
                        req_row    = RW'(rrow_reg);
                        req_col    = CXW'(rcol_reg);
                        state_next = ST_RDA;
                    end
                    else
                    begin
                        cell_char_next = CHAR_BLANK;
                        done_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // Finish in this cycle unless a scroll is started below.
                    cell_char_next = CHAR_NONE;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                    if (esc_reg)
                    begin
                        if (byte_reg inside {[ESC_END_LO:ESC_END_HI]})
                        begin
                            esc_next = 1'b0;
                        end
                    end
                    else
                    begin
                        case (byte_reg)
                            BYTE_ESC:
                            begin
                                esc_next = 1'b1;
                            end
                            BYTE_LF:
                            begin
                                cur_col_next = '0;
                                if (last_row)
                                begin
                                    top_next       = top_adv;
                                    sweep_col_next = '0;
                                    put_next       = 1'b0;
                                    done_next      = 1'b0;
                                    state_next     = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                            end
                            BYTE_CR:
                            begin
                                cur_col_next = '0;
                            end
                            BYTE_BS:
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = cur_col_reg - CCW'(1);
                                end
                            end
                            BYTE_TAB:
                            begin
                                if (tab_stop > (CCW+1)'(COLUMNS))
                                begin
                                    cur_col_next = CCW'(COLUMNS);
                                end
                                else
                                begin
                                    cur_col_next = CCW'(tab_stop);
                                end
                            end
                            default:
                            begin
                                if (byte_reg inside {[PRINT_LO:PRINT_HI]})
                                begin
                                    if (col_at_end)
                                    begin
                                        // Pending wrap: move to the next line first.
                                        cur_col_next = CCW'(1);
                                        if (last_row)
                                        begin
                                            top_next       = top_adv;
                                            sweep_col_next = '0;
                                            put_next       = 1'b1;
                                            done_next      = 1'b0;
                                            state_next     = ST_SCROLL;
                                        end
                                        else
                                        begin
                                            cur_row_next = cur_row_reg + RW'(1);
                                            req_ctl.we   = 1'b1;
                                            req_row      = cur_row_reg + RW'(1);
                                            req_col      = '0;
                                            req_data     = CHAR_W'(byte_reg);
                                        end
                                    end
                                    else
                                    begin
                                        req_ctl.we   = 1'b1;
                                        req_data     = CHAR_W'(byte_reg);
                                        cur_col_next = cur_col_reg + CCW'(1);
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            ST_SCROLL:
            begin
                // Blank the new bottom row, which is the old top row.
                req_ctl.we = 1'b1;
                req_row    = RW'(ROWS - 1);
                req_col    = sweep_col_reg;
                if (sweep_col_reg == CXW'(COLUMNS - 1))
                begin
                    sweep_col_next = '0;
                    if (put_reg)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + CXW'(1);
                end
            end

            ST_PUT:
            begin
                req_ctl.we = 1'b1;
                req_row    = RW'(ROWS - 1);
                req_col    = '0;
                req_data   = CHAR_W'(byte_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_RDA:
            begin
                state_next = ST_RDB;
            end

            ST_RDB:
            begin
                cell_char_next = mem_rdata;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            esc_reg       <= 1'b0;
            top_reg       <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            put_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            esc_reg       <= esc_next;
            top_reg       <= top_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            put_reg       <= put_next;
            done_reg      <= done_next;
        end
    end

    // Item payload and read result: no reset needed.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        byte_reg      <= byte_next;
        rrow_reg      <= rrow_next;
        rcol_reg      <= rcol_next;
        cell_char_reg <= cell_char_next;
    end

    ttcw_addr_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .RW      (RW),
        .CXW     (CXW),
        .AW      (AW)
    ) u_addr_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .top_row  (top_reg),
        .req_ctl  (req_ctl),
        .req_row  (req_row),
        .req_col  (req_col),
        .req_data (req_data),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .mem_data (mem_data)
    );

    ttcw_screen_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_data),
        .rdata (mem_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_char  = cell_char_reg;
    assign cursor_row = CROW_W'(cur_row_reg);
    assign cursor_col = CCOL_W'(cur_col_reg);
    assign in_escape  = esc_reg;

endmodule
`default_nettype wire

// File: rtl/core/ttcw_addr_unit.sv
// Shared address unit: rotate a logical row by the scroll offset, form the cell address.
`default_nettype none
module ttcw_addr_unit
    import ttcw_pkg::*;
#(
    parameter int ROWS    = 32,
    parameter int COLUMNS = 100,
    parameter int RW      = 5,
    parameter int CXW     = 7,
    parameter int AW      = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [RW-1:0]     top_row,
    input  wire mem_ctl_t          req_ctl,
    input  wire logic [RW-1:0]     req_row,
    input  wire logic [CXW-1:0]    req_col,
    input  wire logic [CHAR_W-1:0] req_data,
    output mem_ctl_t               mem_ctl,
    output logic [AW-1:0]          mem_addr,
    output logic [CHAR_W-1:0]      mem_data
);

    mem_ctl_t            ctl_reg;
    logic [AW-1:0]       addr_reg;
    logic [CHAR_W-1:0]   data_reg;
    logic [RW:0]         row_sum;
    logic [RW-1:0]       phys_row;
    logic [AW-1:0]       addr_next;

    // Wrap the rotated row once; both operands stay below ROWS.
    always_comb
    begin
        row_sum  = {1'b0, req_row} + {1'b0, top_row};
        if (row_sum >= (RW+1)'(ROWS))
        begin
            phys_row = RW'(row_sum - (RW+1)'(ROWS));
        end
        else
        begin
            phys_row = RW'(row_sum);
        end
        addr_next = AW'(phys_row) * AW'(COLUMNS) + AW'(req_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= req_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= req_data;
    end

    assign mem_ctl  = ctl_reg;
    assign mem_addr = addr_reg;
    assign mem_data = data_reg;

endmodule
`default_nettype wire

// File: rtl/core/ttcw_screen_mem.sv
// Screen store: single-port character memory with registered read data.
`default_nettype none
module ttcw_screen_mem
    import ttcw_pkg::*;
#(
    parameter int DEPTH = 3200,
    parameter int AW    = 12
)
(
    input  wire logic              clk,
    input  wire mem_ctl_t          ctl,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [CHAR_W-1:0] wdata,
    output logic [CHAR_W-1:0]      rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/ttcw_checker.sv
// Port checker for the character writer, bound to the top level.
`default_nettype none
`include "text_terminal_char_writer_unit_assert.svh"
module ttcw_checker
    import ttcw_pkg::*;
#(
    parameter int COLUMNS = 100
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [CCOL_W-1:0] cursor_col
);

    // A result only appears once the block has gone idle again.
    `TTCW_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    // An accepted item keeps the block busy and cannot finish in the same cycle.
    `TTCW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    // The result strobe lasts one cycle.
    `TTCW_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // The cursor never runs past the pending-wrap column.
    `TTCW_ASSERT_IMPLY(a_col_bound, clk, rst_n, done && (COLUMNS < 128), 32'(cursor_col) <= COLUMNS)

endmodule

bind text_terminal_char_writer_unit ttcw_checker #(
    .COLUMNS (COLUMNS)
) u_ttcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cursor_col (cursor_col)
);
`default_nettype wire
